// ===== hw/rtl/median_filter_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define MF3_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define MF3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MF3_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MF3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mf3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, codes and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int RESET_SIZE     = 2048;

   localparam int PIX_W   = 32;
   localparam int NBANK   = 4;
   localparam int Q_DEPTH = 4;
   localparam int QAW     = $clog2(Q_DEPTH);
   localparam int QCW     = $clog2(Q_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_HEIGHT = 2'd1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;       // {alpha, red, green, blue}
   typedef logic [2:0][PIX_W-1:0] col_type;  // index 0 = upper row

   typedef struct packed {
      logic    last;
      logic    left;
      col_type colc;
      col_type coln;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic room;
   } q_status_type;

   function automatic logic [7:0] min8(input logic [7:0] x, input logic [7:0] y);
      return (x < y) ? x : y;
   endfunction

   function automatic logic [7:0] max8(input logic [7:0] x, input logic [7:0] y);
      return (x > y) ? x : y;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
      return min8(min8(x, y), z);
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
      return max8(max8(x, y), z);
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
      return max8(min8(x, y), min8(max8(x, y), z));
   endfunction

endpackage

// ===== hw/rtl/mf3_front.sv =====
`timescale 1ns / 1ps
`include "median_filter_3x3_assert.svh"
// ----------------------------------------------------------------------------
// mf3_front
// Accepts beats, tracks input/output position, writes the four row banks and
// reads the two window columns each output needs.
// ----------------------------------------------------------------------------
module mf3_front #(
   parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_blue_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_alpha_in,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [11:0]                   csr_data,
   output logic                          push,
   output mf3_pkg::cmd_type              push_cmd,
   input  mf3_pkg::q_status_type         q_status
);
   import mf3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (MAX_WIDTH < RESET_SIZE) ? MAX_WIDTH : RESET_SIZE;
   localparam int H_RST = (MAX_HEIGHT < RESET_SIZE) ? MAX_HEIGHT : RESET_SIZE;

   logic [WW-1:0] wid_ff, wid_in, wid_clamp;
   logic [RW-1:0] hgt_ff, hgt_in, hgt_clamp;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic accept, csr_fire, in_done, is_pix, is_flush, emit;
   logic in_last_col, out_last_col, out_last_row, out_last;
   logic [1:0]    wr_bank;
   logic [CW-1:0] wr_addr, rd_addr_c, rd_addr_n;
   pix_type       wr_data;
   logic [RW-1:0] row_up, row_dn;

   pix_type       rd_c_ff [NBANK];
   pix_type       rd_n_ff [NBANK];
   logic          f1_valid_ff;
   logic          f1_last_ff, f1_left_ff;
   logic [2:0][1:0] f1_sel_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign req_ready = q_status.room;
   assign accept    = req_valid && req_ready;

   // Classify the beat
   assign in_done  = (in_row_ff >= hgt_ff);
   assign is_pix   = accept && (req_mode == MODE_PIXEL) && !in_done;
   assign is_flush = accept && (req_mode == MODE_FLUSH) && in_done && (out_row_ff < hgt_ff);
   assign emit     = is_flush ||
                     (is_pix && ((in_row_ff >= RW'(2)) ||
                                 ((in_row_ff == RW'(1)) && (in_col_ff != '0))));

   assign in_last_col  = (WW'(in_col_ff) == (wid_ff - WW'(1)));
   assign out_last_col = (WW'(out_col_ff) == (wid_ff - WW'(1)));
   assign out_last_row = (out_row_ff == (hgt_ff - RW'(1)));
   assign out_last     = out_last_col && out_last_row;

   // Clamp register writes
   always_comb begin
      if (csr_data == '0) wid_clamp = WW'(1);
      else if (int'(csr_data) > MAX_WIDTH) wid_clamp = WW'(MAX_WIDTH);
      else wid_clamp = WW'(csr_data);
      if (csr_data == '0) hgt_clamp = RW'(1);
      else if (int'(csr_data) > MAX_HEIGHT) hgt_clamp = RW'(MAX_HEIGHT);
      else hgt_clamp = RW'(csr_data);
   end

   // Advance positions; restart the frame on a width or height write or frame end
   always_comb begin
      wid_in     = wid_ff;
      hgt_in     = hgt_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_IDX_WIDTH: begin
               wid_in = wid_clamp;
               in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
            end
            CSR_IDX_HEIGHT: begin
               hgt_in = hgt_clamp;
               in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
            end
            default: ;
         endcase
      end else begin
         if (is_pix) begin
            if (in_last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            if (out_last) begin
               in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
            end else if (out_last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff     <= WW'(W_RST);
         hgt_ff     <= RW'(H_RST);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         wid_ff     <= wid_in;
         hgt_ff     <= hgt_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Window addresses with edge replication
   assign wr_bank   = in_row_ff[1:0];
   assign wr_addr   = in_col_ff;
   assign wr_data   = {req_alpha_in, req_red_in, req_green_in, req_blue_in};
   assign rd_addr_c = out_col_ff;
   assign rd_addr_n = out_last_col ? out_col_ff : (out_col_ff + CW'(1));
   assign row_up    = (out_row_ff == '0) ? out_row_ff : (out_row_ff - RW'(1));
   assign row_dn    = out_last_row ? out_row_ff : (out_row_ff + RW'(1));

   // Row banks: one write port, two read ports, write data forwarded
   for (genvar b = 0; b < NBANK; b++) begin : g_bank
      pix_type line_mem [MAX_WIDTH];
      logic    hit;
      assign hit = is_pix && (wr_bank == 2'(b));
      always_ff @(posedge clock) begin
         if (hit) line_mem[wr_addr] <= wr_data;
         if (emit) begin
            rd_c_ff[b] <= (hit && (wr_addr == rd_addr_c)) ? wr_data : line_mem[rd_addr_c];
            rd_n_ff[b] <= (hit && (wr_addr == rd_addr_n)) ? wr_data : line_mem[rd_addr_n];
         end
      end
   end

   // Hold the command alongside the read data
   always_ff @(posedge clock) begin
      if (reset) f1_valid_ff <= 1'b0;
      else f1_valid_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         f1_last_ff   <= out_last;
         f1_left_ff   <= (out_col_ff == '0);
         f1_sel_ff[0] <= row_up[1:0];
         f1_sel_ff[1] <= out_row_ff[1:0];
         f1_sel_ff[2] <= row_dn[1:0];
      end
   end

   assign push          = f1_valid_ff;
   assign push_cmd.last = f1_last_ff;
   assign push_cmd.left = f1_left_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         push_cmd.colc[k] = rd_c_ff[f1_sel_ff[k]];
         push_cmd.coln[k] = rd_n_ff[f1_sel_ff[k]];
      end
   end

   `MF3_ASSERT_NEXT(a_cfg_restart, clock, reset, csr_fire && (csr_index == CSR_IDX_WIDTH || csr_index == CSR_IDX_HEIGHT), in_row_ff == '0 && out_row_ff == '0 && !f1_valid_ff, "register write did not restart frame")
   `MF3_ASSERT_IMPLY(a_pos_in_range, clock, reset, 1'b1, out_row_ff < hgt_ff && WW'(out_col_ff) < wid_ff, "output position outside frame")

endmodule

// ===== hw/rtl/mf3_queue.sv =====
`timescale 1ns / 1ps
`include "median_filter_3x3_assert.svh"
// ----------------------------------------------------------------------------
// mf3_queue
// Short command queue between the front and the median pipeline.
// ----------------------------------------------------------------------------
module mf3_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mf3_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output mf3_pkg::cmd_type      head,
   output mf3_pkg::q_status_type q_status
);
   import mf3_pkg::*;

   cmd_type        slot_ff [Q_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      if (pop) rd_ptr_in = (rd_ptr_ff == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      if (push && !pop) count_in = count_ff + QCW'(1);
      else if (pop && !push) count_in = count_ff - QCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.room  = (count_ff <= QCW'(Q_DEPTH - 2));

   `MF3_ASSERT_IMPLY(a_q_no_overflow, clock, reset, push && !pop, count_ff < QCW'(Q_DEPTH), "command queue overflow")
   `MF3_ASSERT_IMPLY(a_q_no_underflow, clock, reset, pop, count_ff != '0, "pop from empty command queue")

endmodule

// ===== hw/rtl/mf3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_back
// Builds the 3x3 window and runs the per-channel median network:
// column sort, cross-column select, final median of three.
// ----------------------------------------------------------------------------
module mf3_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mf3_pkg::cmd_type      head,
   input  mf3_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_blue_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_alpha_out,
   output logic                  rsp_frame_end
);
   import mf3_pkg::*;

   logic adv;

   col_type held_ff;
   col_type s1_left_ff, s1_ctr_ff, s1_right_ff, s1_left_in;
   logic    s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic    s1_last_ff, s2_last_ff, s3_last_ff, rsp_last_ff;

   logic [2:0][3:0][7:0] s2_lo_ff, s2_mid_ff, s2_hi_ff, s2_lo_in, s2_mid_in, s2_hi_in;
   logic [3:0][7:0]      s3_a_ff, s3_b_ff, s3_c_ff, s3_a_in, s3_b_in, s3_c_in;
   logic [3:0][7:0]      rsp_pix_ff, rsp_pix_in;
   logic [2:0][2:0][PIX_W-1:0] win;

   // Stall the whole pipeline while a result waits
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_status.empty;

   // Replicate the center column at the left edge
   assign s1_left_in = head.left ? head.colc : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Sort each column, per channel
   assign win[0] = s1_left_ff;
   assign win[1] = s1_ctr_ff;
   assign win[2] = s1_right_ff;
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int ch = 0; ch < 4; ch++) begin
            s2_lo_in[j][ch]  = min3(win[j][0][ch*8 +: 8], win[j][1][ch*8 +: 8],
                                    win[j][2][ch*8 +: 8]);
            s2_mid_in[j][ch] = med3(win[j][0][ch*8 +: 8], win[j][1][ch*8 +: 8],
                                    win[j][2][ch*8 +: 8]);
            s2_hi_in[j][ch]  = max3(win[j][0][ch*8 +: 8], win[j][1][ch*8 +: 8],
                                    win[j][2][ch*8 +: 8]);
         end
      end
   end

   // Largest low, middle of middles, smallest high; then their median
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         s3_a_in[ch]    = max3(s2_lo_ff[0][ch], s2_lo_ff[1][ch], s2_lo_ff[2][ch]);
         s3_b_in[ch]    = med3(s2_mid_ff[0][ch], s2_mid_ff[1][ch], s2_mid_ff[2][ch]);
         s3_c_in[ch]    = min3(s2_hi_ff[0][ch], s2_hi_ff[1][ch], s2_hi_ff[2][ch]);
         rsp_pix_in[ch] = med3(s3_a_ff[ch], s3_b_ff[ch], s3_c_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) held_ff <= head.colc;
      if (adv) begin
         s1_left_ff  <= s1_left_in;
         s1_ctr_ff   <= head.colc;
         s1_right_ff <= head.coln;
         s1_last_ff  <= head.last;
         s2_lo_ff    <= s2_lo_in;
         s2_mid_ff   <= s2_mid_in;
         s2_hi_ff    <= s2_hi_in;
         s2_last_ff  <= s1_last_ff;
         s3_a_ff     <= s3_a_in;
         s3_b_ff     <= s3_b_in;
         s3_c_ff     <= s3_c_in;
         s3_last_ff  <= s2_last_ff;
         rsp_pix_ff  <= rsp_pix_in;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = rsp_pix_ff[0];
   assign rsp_green_out = rsp_pix_ff[1];
   assign rsp_red_out   = rsp_pix_ff[2];
   assign rsp_alpha_out = rsp_pix_ff[3];
   assign rsp_frame_end = rsp_last_ff;

endmodule

// ===== hw/rtl/median_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median over four 8-bit channels with edge replication.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    mode, blue/green/red/alpha_in
//   rsp      out        rsp_valid/rsp_ready    blue/green/red/alpha_out, frame_end
//   csr      in         csr_valid/csr_ready    csr_index, csr_data (12 bit)
//
// One beat per cycle in while the queue has room, one result per cycle out while
// rsp_ready is high. With an empty queue and no stall, the result a beat causes
// passes the bank read register, queue write, window register and three median stages.
// The last min(W+1, W*H) results of a frame are drained by flush beats.
// Synchronous reset; row banks hold no reset state and need no clearing.
// A stalled rsp side stops the median pipeline; req stalls once the
// four-entry command queue cannot take two more entries.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_blue_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_alpha_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_blue_out,
   output logic [7:0]                    rsp_green_out,
   output logic [7:0]                    rsp_red_out,
   output logic [7:0]                    rsp_alpha_out,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [11:0]                   csr_data
);
   import mf3_pkg::*;

   logic         push, pop;
   cmd_type      push_cmd, head;
   q_status_type q_status;

   mf3_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_blue_in (req_blue_in),
      .req_green_in(req_green_in),
      .req_red_in  (req_red_in),
      .req_alpha_in(req_alpha_in),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push),
      .push_cmd    (push_cmd),
      .q_status    (q_status)
   );

   mf3_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .q_status(q_status)
   );

   mf3_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_blue_out (rsp_blue_out),
      .rsp_green_out(rsp_green_out),
      .rsp_red_out  (rsp_red_out),
      .rsp_alpha_out(rsp_alpha_out),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 median filter. A scoreboard class keeps
// its own copy of the row store and the frame counters. For every accepted
// request beat it predicts the median pixel that beat causes, if any. Each
// response beat is checked against the oldest prediction. Frames of many
// sizes are streamed with random gaps and response stalls. The frames
// include the size extremes, ignored beats and register write corners.
// ----------------------------------------------------------------------------
module testbench;
   import mf3_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       frame_end;
   } median_pix_type;

   // Predicts filter output from the accepted request beats
   class median_scoreboard;
      logic [31:0]    rows [4][2048];
      int unsigned    width, height;
      int unsigned    in_row, in_col, out_row, out_col;
      median_pix_type pending [$];
      int             errors;

      function new();
         width = 2048;
         height = 2048;
         errors = 0;
         restart();
         for (int b = 0; b < 4; b++)
            for (int c = 0; c < 2048; c++) rows[b][c] = '0;
      endfunction

      function void restart();
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
      endfunction

      function int unsigned clamp_size(logic [11:0] v);
         int unsigned x;
         x = v;
         if (x < 1) x = 1;
         if (x > 2048) x = 2048;
         return x;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [11:0] data);
         if (idx == CSR_IDX_WIDTH) begin
            width = clamp_size(data);
            restart();
         end else if (idx == CSR_IDX_HEIGHT) begin
            height = clamp_size(data);
            restart();
         end
      endfunction

      function int unsigned edge_clamp(int v, int unsigned n);
         if (v < 0) return 0;
         if (v >= n) return n - 1;
         return v;
      endfunction

      // Build the next median pixel and advance the output position
      function void emit_pixel();
         median_pix_type res;
         logic [7:0]     v [9];
         logic [7:0]     key;
         logic [7:0]     med [4];
         int             n, j;
         int unsigned    rr, cc;
         logic           frame_last;
         frame_last = (out_row == height - 1) && (out_col == width - 1);
         for (int ch = 0; ch < 4; ch++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               rr = edge_clamp(int'(out_row) + dr, height);
               for (int dc = -1; dc <= 1; dc++) begin
                  cc = edge_clamp(int'(out_col) + dc, width);
                  v[n] = rows[rr % 4][cc][ch*8 +: 8];
                  n++;
               end
            end
            for (int i = 1; i < 9; i++) begin
               key = v[i];
               j = i - 1;
               while (j >= 0 && v[j] > key) begin
                  v[j+1] = v[j];
                  j--;
               end
               v[j+1] = key;
            end
            med[ch] = v[4];
         end
         res.blue = med[0];
         res.green = med[1];
         res.red = med[2];
         res.alpha = med[3];
         res.frame_end = frame_last;
         pending.push_back(res);
         if (frame_last) begin
            restart();
         end else begin
            out_col++;
            if (out_col >= width) begin
               out_col = 0;
               out_row++;
            end
         end
      endfunction

      function void note_input(logic mode, logic [31:0] pix);
         int unsigned p;
         if (mode == MODE_FLUSH) begin
            if (in_row >= height || out_row < height) begin
               if (in_row >= height && out_row < height) emit_pixel();
            end
            return;
         end
         if (in_row >= height) return;
         rows[in_row % 4][in_col] = pix;
         p = in_row * width + in_col;
         in_col++;
         if (in_col >= width) begin
            in_col = 0;
            in_row++;
         end
         if (p >= width + 1) emit_pixel();
      endfunction

      function void check_result(median_pix_type got);
         median_pix_type exp_pix;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response beat: %h", got);
            return;
         end
         exp_pix = pending.pop_front();
         if (got !== exp_pix) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected b=%h g=%h r=%h a=%h fe=%b, %s",
                        exp_pix.blue, exp_pix.green, exp_pix.red, exp_pix.alpha,
                        exp_pix.frame_end,
                        $sformatf("got b=%h g=%h r=%h a=%h fe=%b",
                                  got.blue, got.green, got.red, got.alpha,
                                  got.frame_end));
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = MODE_PIXEL;
   logic [7:0]           req_blue_in = '0;
   logic [7:0]           req_green_in = '0;
   logic [7:0]           req_red_in = '0;
   logic [7:0]           req_alpha_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out;
   logic                 rsp_frame_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [11:0]          csr_data = '0;

   median_scoreboard sb = new();
   bit               no_idle = 0;
   bit               long_hold = 0;
   int               beat_count = 0;

   median_filter_3x3 u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in),
      .req_red_in(req_red_in), .req_alpha_in(req_alpha_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue_out(rsp_blue_out), .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out), .rsp_alpha_out(rsp_alpha_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out,
                          rsp_frame_end});
   end

   // Drive response backpressure: runs of ready, short and rare long stalls
   initial begin : rsp_stall_proc
      int  run_left;
      bit  run_val;
      int  r;
      run_left = 0;
      run_val = 1;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 0;
            run_left = 0;
         end
         if (run_left == 0) begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 60) begin
               run_val = 1;
               run_left = $urandom_range(1, 20);
            end else if (r < 95) begin
               run_val = 0;
               run_left = $urandom_range(1, 3);
            end else begin
               run_val = 0;
               run_left = $urandom_range(15, 50);
            end
         end
         rsp_ready <= run_val;
         run_left--;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one request beat; called right after a posedge
   task send_beat(logic mode, logic [31:0] pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      {req_alpha_in, req_red_in, req_green_in, req_blue_in} <= pix;
      do @(posedge clock); while (!req_ready);
      sb.note_input(mode, pix);
      beat_count++;
   endtask

   // Hold until all predictions are drained and the pipeline is quiet
   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function logic [31:0] pick_pixel(int style);
      case (style)
         0: return $urandom();
         1: return '0;
         2: return '1;
         default: return ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) ^
                         ($urandom() & 32'h0101_0101);
      endcase
   endfunction

   // Stream one frame with optional ignored beats mixed in
   task run_frame(int w, int h, int style, bit noise);
      int total, flushes;
      write_csr(CSR_IDX_WIDTH, 12'(w));
      write_csr(CSR_IDX_HEIGHT, 12'(h));
      total = w * h;
      flushes = (w + 1 < total) ? w + 1 : total;
      for (int i = 0; i < total; i++) begin
         if (noise && $urandom_range(0, 19) == 0)
            send_beat(MODE_FLUSH, $urandom());
         send_beat(MODE_PIXEL, pick_pixel(style));
      end
      if (noise && $urandom_range(0, 2) == 0) send_beat(MODE_PIXEL, $urandom());
      for (int i = 0; i < flushes; i++) send_beat(MODE_FLUSH, $urandom());
      if (noise && $urandom_range(0, 3) == 0) send_beat(MODE_FLUSH, $urandom());
      wait_drained();
   endtask

   initial begin : timeout_proc
      #5_000_000;
      $display("median_filter_3x3 verification failed");
      $finish;
   end

   initial begin : main_proc
      int w, h;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // Directed: register corners, unknown indexes, tiny and extreme frames
      write_csr(2'd2, 12'hABC);
      write_csr(2'd3, 12'h543);
      write_csr(CSR_IDX_WIDTH, 12'd0);
      write_csr(CSR_IDX_HEIGHT, 12'd0);
      send_beat(MODE_FLUSH, 32'h0);
      send_beat(MODE_PIXEL, 32'hFFFF_FFFF);
      send_beat(MODE_PIXEL, 32'h1234_5678);
      send_beat(MODE_FLUSH, 32'hFFFF_FFFF);
      send_beat(MODE_FLUSH, 32'h0);
      wait_drained();
      run_frame(3, 3, 3, 1);
      run_frame(1, 5, 0, 1);
      run_frame(5, 1, 0, 1);
      write_csr(CSR_IDX_WIDTH, 12'hFFF);
      write_csr(CSR_IDX_HEIGHT, 12'd2049);
      run_frame(128, 2, 0, 0);
      run_frame(1, 40, 0, 0);
      run_frame(60, 1, 0, 0);

      // Random frames, mostly small; long response holds at random and at the end
      while (beat_count < 1500) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 6);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
         end
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_IDX_W'($urandom_range(2, 3)), 12'($urandom()));
         if (!long_hold && $urandom_range(0, 15) == 0) long_hold = 1;
         run_frame(w, h, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      end
      long_hold = 1;
      run_frame(40, 6, 0, 0);

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("median_filter_3x3 verification clean");
      end else begin
         $display("median_filter_3x3 verification failed");
      end
      $finish;
   end
endmodule
